### src/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// shared types and constants of the banked warp register file
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int CFG_W = 9;

    localparam logic [7:0] ZERO_REG = 8'd255;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [CFG_W-1:0] cfg_word_t;

    typedef struct packed {
        logic        op;
        logic [2:0]  warp_id;
        logic [7:0]  reg_index;
        logic [4:0]  lane;
        logic        lane_active;
        logic [1:0]  word_slice;
        logic [31:0] write_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_word;
        logic        read_valid;
        logic [4:0]  lane_out;
        logic [1:0]  slice_out;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_REDUCE,
        ST_ACCESS,
        ST_READ
    } state_t;

    typedef struct packed {
        logic load_item;
        logic load_row;
        logic reduce_step;
        logic mem_access;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic row_in_range;
    } dp_status_t;

endpackage

### src/brf_if.sv
// ----------------------------------------------------------------------------
// brf interfaces
// valid/ready channels for requests, results and the count register
// ----------------------------------------------------------------------------
interface brf_req_if import brf_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brf_rsp_if import brf_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brf_cfg_if import brf_pkg::*; ();
    logic      valid;
    logic      ready;
    cfg_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/gpu_banked_register_file_unit.sv
// ----------------------------------------------------------------------------
// gpu_banked_register_file_unit
// warp register file, one lane word per transfer, banked by register number
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | op, warp_id, reg_index, lane, lane_active,
//          |     |              | word_slice, write_word
//  rsp     | out | valid/ready  | read_word, read_valid, lane_out, slice_out
//  cfg     | in  | valid/ready  | regs_per_thread (always ready)
//
//  one item at a time: accept, decode, bank access, read data, with the
//  iterative row wrap between decode and bank access when the raw row falls
//  outside the bank (never needed at the default sizes)
//  the bank memories are not cleared, so reset takes effect at once
//  the result register holds while rsp is stalled; a new request is taken
//  while an earlier result still waits
// ----------------------------------------------------------------------------
module gpu_banked_register_file_unit import brf_pkg::*; #(
    parameter int LANES    = 32,
    parameter int BANKS    = 4,
    parameter int WARPS    = 8,
    parameter int MAX_REGS = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    brf_req_if.sink       req,
    brf_rsp_if.source     rsp,
    brf_cfg_if.sink       cfg
);

    localparam int ROWS    = (WARPS * MAX_REGS + BANKS - 1) / BANKS;
    localparam int CNT_MAX = (MAX_REGS + BANKS - 1) / BANKS;
    localparam int RAW_MAX = (WARPS - 1) * CNT_MAX + 255 / BANKS;
    localparam int RAW_W   = (RAW_MAX > 0) ? $clog2(RAW_MAX + 1) : 1;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    brf_controller #(
        .STEPS (RAW_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    brf_datapath #(
        .LANES    (LANES),
        .BANKS    (BANKS),
        .WARPS    (WARPS),
        .MAX_REGS (MAX_REGS),
        .ROWS     (ROWS),
        .CNT_MAX  (CNT_MAX),
        .RAW_W    (RAW_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.data),
        .item_in  (req.data),
        .cmd      (cmd),
        .status   (status),
        .result   (rsp.data)
    );

endmodule

### src/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram
// single port ram with registered read data
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                     wdata,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_array[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_array[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/brf_controller.sv
// ----------------------------------------------------------------------------
// brf_controller
// sequencer for decode, row wrap, bank access and result hand-off
// ----------------------------------------------------------------------------
module brf_controller import brf_pkg::*; #(
    parameter int STEPS = 9
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.load_row = 1'b1;
                step_next    = STEP_W'(STEPS - 1);
                state_next   = status.row_in_range ? ST_ACCESS : ST_REDUCE;
            end
            ST_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_ACCESS;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_ACCESS:
            begin
                cmd.mem_access = 1'b1;
                state_next     = ST_READ;
            end
            ST_READ:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### src/brf_datapath.sv
// ----------------------------------------------------------------------------
// brf_datapath
// address decode, row wrap unit, bank memories and result register
// ----------------------------------------------------------------------------
module brf_datapath import brf_pkg::*; #(
    parameter int LANES    = 32,
    parameter int BANKS    = 4,
    parameter int WARPS    = 8,
    parameter int MAX_REGS = 256,
    parameter int ROWS     = 512,
    parameter int CNT_MAX  = 64,
    parameter int RAW_W    = 9
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  cfg_word_t  cfg_data,
    input  in_item_t   item_in,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_item_t  result
);

    localparam int CNT_W     = $clog2(CNT_MAX + 1);
    localparam int CNT_RST_N = (MAX_REGS < 64) ? MAX_REGS : 64;
    localparam int CNT_RST   = (CNT_RST_N + BANKS - 1) / BANKS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RED_W     = RAW_W + ROW_W + 1;
    localparam int BANK_W    = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int WARP_W    = (WARPS > 1) ? $clog2(WARPS) : 1;
    localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int DEPTH     = ROWS * LANES;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [255:0][7:0] build_div(input int b);
        logic [255:0][7:0] t;
        int                q;
        int                m;
        q = 0;
        m = 0;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 8'(q);
            m++;
            if (m == b)
            begin
                m = 0;
                q++;
            end
        end
        return t;
    endfunction

    function automatic logic [255:0][BANK_W-1:0] build_mod(input int b);
        logic [255:0][BANK_W-1:0] t;
        int                       m;
        m = 0;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = BANK_W'(m);
            m++;
            if (m == b)
            begin
                m = 0;
            end
        end
        return t;
    endfunction

    function automatic logic [WARP_W-1:0] wrap_warp(input logic [2:0] w);
        int v;
        v = int'(w);
        for (int i = 0; i < 8; i++)
        begin
            if (v >= WARPS)
            begin
                v = v - WARPS;
            end
        end
        return WARP_W'(v);
    endfunction

    localparam logic [255:0][7:0]        REG_DIV = build_div(BANKS);
    localparam logic [255:0][BANK_W-1:0] REG_MOD = build_mod(BANKS);

    in_item_t          item_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [RAW_W-1:0]  row_reg;
    logic [RED_W-1:0]  div_reg;
    out_item_t         result_reg;

    cfg_word_t         n_sat;
    logic [RAW_W-1:0]  prod;
    logic [RAW_W-1:0]  raw_next;
    logic [RED_W-1:0]  row_ext;
    logic [ROW_W-1:0]  row_fin;
    logic [LANE_W-1:0] col;
    logic [AW-1:0]     addr;
    logic [BANK_W-1:0] bank_sel;
    logic              act;
    logic              nonzero;
    logic              do_read;
    logic              do_write;
    logic              mem_use;
    logic [31:0]       bank_rdata [BANKS];

    // rounded count over banks, kept as rows per warp
    always_comb
    begin
        n_sat = (cfg_data > CFG_W'(MAX_REGS)) ? CFG_W'(MAX_REGS) : cfg_data;
        if (n_sat == '0)
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = CNT_W'(REG_DIV[8'(n_sat - 1'b1)]) + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_W'(CNT_RST);
        end
        else if (cfg_we)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // row before wrap: warp * rows per warp + register / banks
    assign prod     = RAW_W'(wrap_warp(item_reg.warp_id)) * RAW_W'(cnt_reg);
    assign raw_next = prod + RAW_W'(REG_DIV[item_reg.reg_index]);
    assign row_ext  = RED_W'(row_reg);

    assign status.row_in_range = (RED_W'(raw_next) < RED_W'(ROWS));

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item_in;
        end
        if (cmd.load_row)
        begin
            row_reg <= raw_next;
            div_reg <= RED_W'(ROWS) << (RAW_W - 1);
        end
        else if (cmd.reduce_step)
        begin
            if (row_ext >= div_reg)
            begin
                row_reg <= RAW_W'(row_ext - div_reg);
            end
            div_reg <= div_reg >> 1;
        end
    end

    assign act      = item_reg.lane_active && (int'(item_reg.lane) < LANES);
    assign nonzero  = (item_reg.reg_index != ZERO_REG);
    assign do_read  = act && (item_reg.op == OP_READ);
    assign do_write = act && (item_reg.op == OP_WRITE) && nonzero;
    assign mem_use  = do_write || (do_read && nonzero);
    assign bank_sel = REG_MOD[item_reg.reg_index];
    assign col      = LANE_W'(item_reg.lane);
    assign row_fin  = ROW_W'(row_reg);
    assign addr     = AW'(int'(row_fin) * LANES + int'(col));

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        brf_ram #(
            .WIDTH (32),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .en    (cmd.mem_access && mem_use && (bank_sel == BANK_W'(b))),
            .we    (do_write),
            .addr  (addr),
            .wdata (item_reg.write_word),
            .rdata (bank_rdata[b])
        );
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            result_reg.read_word  <= (do_read && nonzero) ? bank_rdata[bank_sel] : '0;
            result_reg.read_valid <= do_read;
            result_reg.lane_out   <= item_reg.lane;
            result_reg.slice_out  <= item_reg.word_slice;
        end
    end

    assign result = result_reg;

endmodule

### src/brf_checker.sv
// ----------------------------------------------------------------------------
// brf_checker
// port level checks of the register file, bound to the top level
// ----------------------------------------------------------------------------
module brf_checker import brf_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input out_item_t rsp_data
);

    // a stalled result stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("result payload changed while stalled");

    // an accepted request keeps the input closed while it is in flight
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready ##1 !req_ready)
        else $error("request taken while previous one in flight");

    // a fresh result only comes out of a busy cycle
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result appeared without a request in flight");

endmodule

bind gpu_banked_register_file_unit brf_checker u_brf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the banked warp register file against a lane-word store kept in the
// bench. Every accepted request updates that store and queues the expected
// result. Results are compared field by field in order. The run covers several
// register counts and changing idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import brf_pkg::*;

    localparam int LANES         = 32;
    localparam int BANKS         = 4;
    localparam int WARPS         = 8;
    localparam int MAX_REGS      = 256;
    localparam int ROWS          = (WARPS * MAX_REGS + BANKS - 1) / BANKS;
    localparam int WORDS         = BANKS * ROWS * LANES;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 4000;
    localparam int RECENT_DEPTH  = 48;

    typedef struct packed {
        logic [2:0] warp;
        logic [7:0] regno;
        logic [4:0] lane;
    } reg_loc_t;

    logic clk;
    logic rst_n;

    brf_req_if req_ch ();
    brf_rsp_if rsp_ch ();
    brf_cfg_if cfg_ch ();

    gpu_banked_register_file_unit #(
        .LANES    (LANES),
        .BANKS    (BANKS),
        .WARPS    (WARPS),
        .MAX_REGS (MAX_REGS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    logic [31:0] lane_words [WORDS];
    bit          word_written [WORDS];
    cfg_word_t   thread_regs;
    out_item_t   expected_results [$];
    reg_loc_t    recent_writes [$];
    int          fail_count;
    int          sent_count;
    int          checked_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int word_slot(logic [2:0] warp, logic [7:0] regno, logic [4:0] lane);
        int count;
        int row;
        int bank;
        count = (int'(thread_regs) > MAX_REGS) ? MAX_REGS : int'(thread_regs);
        count = ((count + BANKS - 1) / BANKS) * BANKS;
        bank  = int'(regno) % BANKS;
        row   = (((int'(warp) % WARPS) * count + int'(regno)) / BANKS) % ROWS;
        return (bank * ROWS + row) * LANES + int'(lane);
    endfunction

    function automatic out_item_t register_access(in_item_t item);
        out_item_t res;
        int        slot;
        res           = '0;
        res.lane_out  = item.lane;
        res.slice_out = item.word_slice;
        if (item.lane_active && int'(item.lane) < LANES)
        begin
            slot = word_slot(item.warp_id, item.reg_index, item.lane);
            if (item.op == OP_READ)
            begin
                res.read_valid = 1'b1;
                if (item.reg_index != ZERO_REG)
                    res.read_word = lane_words[slot];
            end
            else if (item.reg_index != ZERO_REG)
            begin
                lane_words[slot]   = item.write_word;
                word_written[slot] = 1'b1;
            end
        end
        return res;
    endfunction

    // drive at the falling edge, sample the transfer at the rising edge
    task automatic push_request(in_item_t item);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        // a read of a never written word would be undefined, store it instead
        if (item.op == OP_READ && item.lane_active && item.reg_index != ZERO_REG
            && !word_written[word_slot(item.warp_id, item.reg_index, item.lane)])
            item.op = OP_WRITE;
        req_ch.valid = 1'b1;
        req_ch.data  = item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_results.push_back(register_access(item));
        sent_count++;
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_thread_regs(cfg_word_t value);
        wait_results_drained();
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        thread_regs = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic run_random(int count);
        in_item_t item;
        reg_loc_t loc;
        int       pick;
        repeat (count)
        begin
            item.op          = OP_READ;
            item.warp_id     = 3'($urandom_range(0, 7));
            item.reg_index   = 8'($urandom_range(0, 255));
            item.lane        = 5'($urandom_range(0, 31));
            item.lane_active = 1'b1;
            item.word_slice  = 2'($urandom_range(0, 3));
            item.write_word  = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                item.op = OP_WRITE;
                recent_writes.push_back({item.warp_id, item.reg_index, item.lane});
                if (recent_writes.size() > RECENT_DEPTH)
                    void'(recent_writes.pop_front());
            end
            else if (pick < 75 && recent_writes.size() != 0)
            begin
                // read back a recently written register
                loc = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
                item.warp_id   = loc.warp;
                item.reg_index = loc.regno;
                item.lane      = loc.lane;
            end
            else if (pick < 85)
                item.op = OP_READ;
            else if (pick < 93)
            begin
                item.op          = 1'($urandom_range(0, 1));
                item.lane_active = 1'b0;
            end
            else
            begin
                item.op        = 1'($urandom_range(0, 1));
                item.reg_index = ZERO_REG;
            end
            push_request(item);
        end
    endtask

    task automatic test_directed_access();
        push_request('{OP_WRITE, 3'd0, 8'd0,   5'd0,  1'b1, 2'd0, 32'h0000_0000});
        push_request('{OP_READ,  3'd0, 8'd0,   5'd0,  1'b1, 2'd0, 32'h0000_0000});
        push_request('{OP_WRITE, 3'd7, 8'd254, 5'd31, 1'b1, 2'd3, 32'hffff_ffff});
        push_request('{OP_READ,  3'd7, 8'd254, 5'd31, 1'b1, 2'd3, 32'h0000_0000});
        // zero register
        push_request('{OP_WRITE, 3'd7, 8'd255, 5'd31, 1'b1, 2'd1, 32'ha5a5_a5a5});
        push_request('{OP_READ,  3'd7, 8'd255, 5'd31, 1'b1, 2'd2, 32'hffff_ffff});
        // inactive lanes
        push_request('{OP_WRITE, 3'd0, 8'd0,   5'd0,  1'b0, 2'd2, 32'h1234_5678});
        push_request('{OP_READ,  3'd0, 8'd0,   5'd0,  1'b1, 2'd1, 32'h0000_0000});
        push_request('{OP_READ,  3'd3, 8'd7,   5'd5,  1'b0, 2'd3, 32'hffff_ffff});
        push_request('{OP_READ,  3'd0, 8'd255, 5'd0,  1'b0, 2'd3, 32'h0000_0000});
        // one register in each of banks 1, 2 and 3
        push_request('{OP_WRITE, 3'd3, 8'd1,   5'd16, 1'b1, 2'd0, 32'h5a5a_5a5a});
        push_request('{OP_WRITE, 3'd3, 8'd2,   5'd16, 1'b1, 2'd1, 32'hc3c3_c3c3});
        push_request('{OP_WRITE, 3'd3, 8'd3,   5'd16, 1'b1, 2'd2, 32'h0f0f_f0f0});
        push_request('{OP_READ,  3'd3, 8'd1,   5'd16, 1'b1, 2'd3, 32'h0000_0000});
        push_request('{OP_READ,  3'd3, 8'd2,   5'd16, 1'b1, 2'd2, 32'h0000_0000});
        push_request('{OP_READ,  3'd3, 8'd3,   5'd16, 1'b1, 2'd1, 32'h0000_0000});
        // warp boundary at the default count
        push_request('{OP_WRITE, 3'd1, 8'd63,  5'd0,  1'b1, 2'd0, 32'h8000_0001});
        push_request('{OP_WRITE, 3'd2, 8'd0,   5'd0,  1'b1, 2'd0, 32'h7fff_fffe});
        push_request('{OP_READ,  3'd1, 8'd63,  5'd0,  1'b1, 2'd0, 32'h0000_0000});
        push_request('{OP_READ,  3'd2, 8'd0,   5'd0,  1'b1, 2'd0, 32'h0000_0000});
    endtask

    task automatic test_default_count();
        run_random(80);
        wait_results_drained();
        run_random(70);
    endtask

    task automatic test_count_extremes();
        write_thread_regs(9'd256);
        run_random(110);
        send_idle_pct = 47;
        recv_idle_pct = 35;
        write_thread_regs(9'd1);
        run_random(110);
        // all warps share rows
        write_thread_regs(9'd0);
        run_random(110);
        // saturated to the largest count
        write_thread_regs(9'd511);
        run_random(110);
    endtask

    task automatic test_random_counts();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_thread_regs(9'($urandom_range(2, 510)));
        run_random(110);
        write_thread_regs(9'd64);
        run_random(110);
    endtask

    always @(negedge clk)
        rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no request pending: %p", rsp_ch.data);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                checked_count++;
                if (rsp_ch.data.read_word !== want.read_word)
                begin
                    $error("read_word: expected %h, got %h", want.read_word,
                           rsp_ch.data.read_word);
                    fail_count++;
                end
                if (rsp_ch.data.read_valid !== want.read_valid)
                begin
                    $error("read_valid: expected %b, got %b", want.read_valid,
                           rsp_ch.data.read_valid);
                    fail_count++;
                end
                if (rsp_ch.data.lane_out !== want.lane_out)
                begin
                    $error("lane_out: expected %0d, got %0d", want.lane_out,
                           rsp_ch.data.lane_out);
                    fail_count++;
                end
                if (rsp_ch.data.slice_out !== want.slice_out)
                begin
                    $error("slice_out: expected %0d, got %0d", want.slice_out,
                           rsp_ch.data.slice_out);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        rsp_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        thread_regs   = 9'd64;
        fail_count    = 0;
        sent_count    = 0;
        checked_count = 0;
        idle_cycles   = 0;
        send_idle_pct = 35;
        recv_idle_pct = 47;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_access();
        test_default_count();
        test_count_extremes();
        test_random_counts();
        wait_results_drained();

        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 sent_count, checked_count, fail_count);
        $display("reads, writes, zero register and inactive lanes at counts 64, 256, 1, 0, 511 %s",
                 "and a random count, with three idle patterns");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
